FILE: rtl/tmq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmq_pkg
// Shared constants, payload types and helpers for the ticketed multi queue.
// ----------------------------------------------------------------------------
package tmq_pkg;

  localparam int QUEUE_COUNT = 8;
  localparam int QUEUE_DEPTH = 8;

  localparam int QUEUE_W = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
  localparam int IDX_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W  = QUEUE_W + IDX_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;

  localparam int TICKET_W = 32;
  localparam int QNUM_W   = 8;
  localparam int NUMQ_W   = 4;

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_ENQUEUE = 2'd1,
    CMD_REMOVE  = 2'd2,
    CMD_QUERY   = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t                command;
    logic [QNUM_W-1:0]   queue_number;
    logic [TICKET_W-1:0] ticket;
  } in_item_t;

  typedef struct packed {
    logic [TICKET_W-1:0] issued_ticket;
    logic                is_waiting;
    logic                is_free;
    logic                overflow;
  } out_item_t;

  typedef struct packed {
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [TICKET_W-1:0] wr_data;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
  } mem_req_t;

  // Entry i of queue q sits at a fixed slot of the ticket store.
  function automatic logic [ADDR_W-1:0] mem_addr(input logic [QUEUE_W-1:0] q,
                                                 input logic [IDX_W-1:0] i);
    return {q, i};
  endfunction

endpackage
`default_nettype wire

FILE: rtl/ticketed_multi_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ticketed_multi_queue
// Set of small ordered ticket queues with a shared ticket counter.
//
//   Channel   Ports                          Direction   Contents
//   in        in_valid, in_stall, in_item    input       command item
//   out       out_valid, out_stall, out_item output      one result per item
//   cfg       cfg_wr_en, cfg_wr_data         input       num_queues register
//
// Clear and enqueue go from EXEC to DONE; query reads the queue head in SCAN,
// and remove walks SCAN over entries up to the match and SHIFT over the entries
// moved down, one at a time through the single read and write port of the store.
// Reset is synchronous and active low; it empties all queues at once.
// A result waits in the output register while the next item is accepted.
// ----------------------------------------------------------------------------
module ticketed_multi_queue (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire tmq_pkg::in_item_t          in_item,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output tmq_pkg::out_item_t              out_item,
  input  wire logic                       cfg_wr_en,
  input  wire logic [tmq_pkg::NUMQ_W-1:0] cfg_wr_data
);

  logic [tmq_pkg::NUMQ_W-1:0]   num_queues_r, num_queues_nxt;
  logic                         out_valid_r, out_valid_nxt;
  tmq_pkg::out_item_t           out_item_r, out_item_nxt;

  logic                         busy;
  logic                         in_accept;
  logic                         res_valid;
  logic                         res_take;
  tmq_pkg::out_item_t           res_item;
  tmq_pkg::mem_req_t            mem_req;
  logic [tmq_pkg::TICKET_W-1:0] mem_rd_data;

  assign in_stall  = busy;
  assign in_accept = in_valid && !busy;
  assign res_take  = res_valid && (!out_valid_r || !out_stall);

  assign num_queues_nxt = cfg_wr_en ? cfg_wr_data : num_queues_r;
  assign out_valid_nxt  = res_take || (out_valid_r && out_stall);
  assign out_item_nxt   = res_take ? res_item : out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_queues_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      num_queues_r <= num_queues_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  tmq_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .num_queues  (num_queues_r),
    .in_accept   (in_accept),
    .in_item     (in_item),
    .busy        (busy),
    .res_valid   (res_valid),
    .res_take    (res_take),
    .res_item    (res_item),
    .mem_req     (mem_req),
    .mem_rd_data (mem_rd_data)
  );

  tmq_ram #(
    .WIDTH (tmq_pkg::TICKET_W),
    .DEPTH (tmq_pkg::MEM_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_req.wr_en),
    .wr_addr (mem_req.wr_addr),
    .wr_data (mem_req.wr_data),
    .rd_en   (mem_req.rd_en),
    .rd_addr (mem_req.rd_addr),
    .rd_data (mem_rd_data)
  );

endmodule
`default_nettype wire

FILE: rtl/tmq_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tmq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/tmq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmq_ctrl
// Command sequencer: fill counts, ticket counter, the read walk over the ticket
// store for remove and query, and the read-modify-write compaction for remove.
// ----------------------------------------------------------------------------
module tmq_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [tmq_pkg::NUMQ_W-1:0]    num_queues,
  input  wire logic                          in_accept,
  input  wire tmq_pkg::in_item_t             in_item,
  output logic                               busy,
  output logic                               res_valid,
  input  wire logic                          res_take,
  output tmq_pkg::out_item_t                 res_item,
  output tmq_pkg::mem_req_t                  mem_req,
  input  wire logic [tmq_pkg::TICKET_W-1:0]  mem_rd_data
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_SHIFT = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t                           state_r, state_nxt;
  tmq_pkg::in_item_t                item_r, item_nxt;
  tmq_pkg::out_item_t               res_r, res_nxt;
  logic [tmq_pkg::IDX_W-1:0]        idx_r, idx_nxt;
  logic [tmq_pkg::FILL_W-1:0]       fill_r [tmq_pkg::QUEUE_COUNT];
  logic [tmq_pkg::FILL_W-1:0]       fill_nxt [tmq_pkg::QUEUE_COUNT];
  logic [tmq_pkg::TICKET_W-1:0]     cnt_r, cnt_nxt;

  logic                             q_valid;
  logic [tmq_pkg::QUEUE_W-1:0]      q_idx;
  logic [tmq_pkg::FILL_W-1:0]       fill_cur;
  logic [tmq_pkg::FILL_W-1:0]       idx_ext;
  logic                             hit;

  assign q_valid = (item_r.queue_number < tmq_pkg::QNUM_W'(num_queues)) &&
                   (item_r.queue_number < tmq_pkg::QNUM_W'(tmq_pkg::QUEUE_COUNT));
  assign q_idx    = q_valid ? item_r.queue_number[tmq_pkg::QUEUE_W-1:0] : '0;
  assign fill_cur = fill_r[q_idx];
  assign idx_ext  = tmq_pkg::FILL_W'(idx_r);
  assign hit      = (mem_rd_data == item_r.ticket);

  assign busy      = (state_r != S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res_item  = res_r;

  always_comb begin
    state_nxt = state_r;
    item_nxt  = item_r;
    res_nxt   = res_r;
    idx_nxt   = idx_r;
    fill_nxt  = fill_r;
    cnt_nxt   = cnt_r;
    mem_req   = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          item_nxt  = in_item;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        res_nxt         = '0;
        res_nxt.is_free = !q_valid || (fill_cur == '0);
        state_nxt       = S_DONE;
        case (item_r.command) inside
          tmq_pkg::CMD_CLEAR: begin
            for (int k = 0; k < tmq_pkg::QUEUE_COUNT; k++) begin
              fill_nxt[k] = '0;
            end
            cnt_nxt         = '0;
            res_nxt.is_free = 1'b1;
          end
          tmq_pkg::CMD_ENQUEUE: begin
            cnt_nxt               = cnt_r + 1'b1;
            res_nxt.issued_ticket = cnt_r + 1'b1;
            if (q_valid) begin
              if (fill_cur >= tmq_pkg::FILL_W'(tmq_pkg::QUEUE_DEPTH)) begin
                res_nxt.overflow = 1'b1;
              end else begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = tmq_pkg::mem_addr(q_idx,
                                                    fill_cur[tmq_pkg::IDX_W-1:0]);
                mem_req.wr_data = cnt_r + 1'b1;
                fill_nxt[q_idx] = fill_cur + 1'b1;
              end
              res_nxt.is_free = 1'b0;
            end
          end
          tmq_pkg::CMD_REMOVE, tmq_pkg::CMD_QUERY: begin
            if (q_valid && (fill_cur != '0)) begin
              mem_req.rd_en   = 1'b1;
              mem_req.rd_addr = tmq_pkg::mem_addr(q_idx, '0);
              idx_nxt         = '0;
              state_nxt       = S_SCAN;
            end else if (item_r.command == tmq_pkg::CMD_QUERY) begin
              // An empty valid queue reports waiting.
              res_nxt.is_waiting = q_valid;
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_SCAN: begin
        // Read data holds entry idx_r of the addressed queue.
        if (item_r.command == tmq_pkg::CMD_QUERY) begin
          res_nxt.is_waiting = !hit;
          state_nxt          = S_DONE;
        end else if (hit) begin
          if (idx_ext + 1'b1 < fill_cur) begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = tmq_pkg::mem_addr(q_idx, idx_r + 1'b1);
            state_nxt       = S_SHIFT;
          end else begin
            fill_nxt[q_idx] = fill_cur - 1'b1;
            res_nxt.is_free = (fill_cur - 1'b1 == '0);
            state_nxt       = S_DONE;
          end
        end else if (idx_ext + 1'b1 < fill_cur) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = tmq_pkg::mem_addr(q_idx, idx_r + 1'b1);
          idx_nxt         = idx_r + 1'b1;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SHIFT: begin
        // Read data holds entry idx_r + 1; move it down one slot.
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = tmq_pkg::mem_addr(q_idx, idx_r);
        mem_req.wr_data = mem_rd_data;
        idx_nxt         = idx_r + 1'b1;
        if (idx_ext + 2'd2 < fill_cur) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = tmq_pkg::mem_addr(q_idx, idx_r + 2'd2);
        end else begin
          fill_nxt[q_idx] = fill_cur - 1'b1;
          res_nxt.is_free = (fill_cur - 1'b1 == '0);
          state_nxt       = S_DONE;
        end
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      for (int k = 0; k < tmq_pkg::QUEUE_COUNT; k++) begin
        fill_r[k] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      fill_r  <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r  <= res_nxt;
    idx_r  <= idx_nxt;
  end

`ifndef NO_ASSERTIONS
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == S_EXEC))
    else $error("accepted item did not start execution");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.wr_en |-> ((state_r == S_EXEC) || (state_r == S_SHIFT)))
    else $error("ticket store written outside enqueue or compaction");

  a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |-> (idx_ext + 1'b1 < fill_cur))
    else $error("compaction reads beyond the queue fill");

  a_take_returns: assert property (@(posedge clk) disable iff (!rst_n)
    res_take |=> (state_r == S_IDLE))
    else $error("sequencer did not return to idle after handing off a result");
`endif

endmodule
`default_nettype wire
